[hdl/tlg_pkg.sv]
package tlg_pkg;

  localparam int GRID_ROWS_W = 6;
  localparam int GRID_COLS_W = 7;
  localparam int CFG_DATA_W  = 7;
  localparam int CFG_IDX_W   = 1;

  localparam int OP_W   = 2;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 6;

  localparam logic [GRID_ROWS_W-1:0] GRID_ROWS_RST = 6'd20;
  localparam logic [GRID_COLS_W-1:0] GRID_COLS_RST = 7'd40;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_WR_WB,
    ST_RD_CAP,
    ST_ADV_LAST,
    ST_ADV_FIRST,
    ST_ADV_CUR,
    ST_ADV_ROW,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    RA_ROW,
    RA_LAST,
    RA_ZERO,
    RA_NEXT1,
    RA_NEXT2
  } rd_sel_e;

  typedef struct packed {
    logic    capture;
    rd_sel_e rd_sel;
    logic    wr_cell;
    logic    load_prev;
    logic    load_first;
    logic    adv_row;
    logic    cap_read;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic last_row;
  } status_t;

endpackage

[hdl/tlg_if.sv]
interface tlg_in_if;
  import tlg_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic             cell_in;

  modport source (output valid, output operation, output row, output col, output cell_in,
                  input ready);
  modport sink (input valid, input operation, input row, input col, input cell_in,
                output ready);
endinterface

interface tlg_out_if;
  logic valid;
  logic ready;
  logic cell_out;

  modport source (output valid, output cell_out, input ready);
  modport sink (input valid, input cell_out, output ready);
endinterface

[hdl/tlg_ram.sv]
module tlg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/tlg_rule.sv]
module tlg_rule #(
  parameter int MAX_COLS = 64
) (
  input  logic [MAX_COLS-1:0]             prev_i,
  input  logic [MAX_COLS-1:0]             cur_i,
  input  logic [MAX_COLS-1:0]             down_i,
  input  logic [tlg_pkg::GRID_COLS_W-1:0] eff_cols_i,
  output logic [MAX_COLS-1:0]             next_o
);
  import tlg_pkg::*;

  localparam int ColAw = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic [ColAw-1:0] last_col;
  logic             prev_wl, cur_wl, down_wl;

  // The left neighbor of column 0 is the last column in use.
  assign last_col = ColAw'(eff_cols_i - GRID_COLS_W'(1));
  assign prev_wl  = prev_i[last_col];
  assign cur_wl   = cur_i[last_col];
  assign down_wl  = down_i[last_col];

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
    logic [2:0] lft, rgt;
    logic [3:0] cnt;
    logic       born;

    if (c == 0) begin : g_first
      assign lft = {prev_wl, cur_wl, down_wl};
    end else begin : g_mid
      assign lft = {prev_i[c-1], cur_i[c-1], down_i[c-1]};
    end

    if (c == MAX_COLS - 1) begin : g_last
      assign rgt = {prev_i[0], cur_i[0], down_i[0]};
    end else begin : g_inner
      logic at_end;
      assign at_end = ({1'b0, eff_cols_i} == (GRID_COLS_W + 1)'(c + 1));
      assign rgt = at_end ? {prev_i[0], cur_i[0], down_i[0]}
                          : {prev_i[c+1], cur_i[c+1], down_i[c+1]};
    end

    assign cnt = 4'(lft[2]) + 4'(lft[1]) + 4'(lft[0]) + 4'(rgt[2]) + 4'(rgt[1])
               + 4'(rgt[0]) + 4'(prev_i[c]) + 4'(down_i[c]);
    assign born = (cnt == 4'd3) || (cur_i[c] && (cnt == 4'd2));

    // Columns beyond the area in use keep their value.
    assign next_o[c] = ({1'b0, eff_cols_i} > (GRID_COLS_W + 1)'(c)) ? born : cur_i[c];
  end

endmodule

[hdl/tlg_ctrl.sv]
module tlg_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tlg_pkg::status_t status_i,
  output tlg_pkg::cmd_t    cmd_o
);
  import tlg_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        case (status_i.op)
          OP_WRITE:   state_d = ST_WR_WB;
          OP_ADVANCE: state_d = ST_ADV_LAST;
          OP_READ:    state_d = ST_RD_CAP;
          default:    state_d = ST_DONE;
        endcase
      end
      ST_WR_WB:     state_d = ST_DONE;
      ST_RD_CAP:    state_d = ST_DONE;
      ST_ADV_LAST:  state_d = ST_ADV_FIRST;
      ST_ADV_FIRST: state_d = ST_ADV_CUR;
      ST_ADV_CUR:   state_d = ST_ADV_ROW;
      ST_ADV_ROW: begin
        if (status_i.last_row) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.rd_sel = RA_ROW;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DECODE: cmd_o.rd_sel = RA_ROW;
      ST_WR_WB:  cmd_o.wr_cell = 1'b1;
      ST_RD_CAP: cmd_o.cap_read = 1'b1;
      ST_ADV_LAST: cmd_o.rd_sel = RA_LAST;
      ST_ADV_FIRST: begin
        cmd_o.load_prev = 1'b1;
        cmd_o.rd_sel    = RA_ZERO;
      end
      ST_ADV_CUR: begin
        cmd_o.load_first = 1'b1;
        cmd_o.rd_sel     = RA_NEXT1;
      end
      ST_ADV_ROW: begin
        cmd_o.adv_row = 1'b1;
        cmd_o.rd_sel  = RA_NEXT2;
      end
      ST_DONE: cmd_o.load_out = slot_free;
      default: cmd_o.rd_sel = RA_ROW;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hdl/tlg_dpath.sv]
module tlg_dpath #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tlg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tlg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [tlg_pkg::OP_W-1:0]       operation_i,
  input  logic [tlg_pkg::ROW_W-1:0]      row_i,
  input  logic [tlg_pkg::COL_W-1:0]      col_i,
  input  logic                           cell_in_i,
  output logic                           cell_out_o,
  input  tlg_pkg::cmd_t                  cmd_i,
  output tlg_pkg::status_t               status_o
);
  import tlg_pkg::*;

  localparam int RowAw = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ColAw = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RcW   = ((RowAw > GRID_ROWS_W) ? RowAw : GRID_ROWS_W) + 1;
  localparam int CcW   = ((ColAw > GRID_COLS_W) ? ColAw : GRID_COLS_W) + 1;

  logic [GRID_ROWS_W-1:0] grid_rows_q;
  logic [GRID_COLS_W-1:0] grid_cols_q;
  logic [GRID_ROWS_W-1:0] eff_rows;
  logic [GRID_COLS_W-1:0] eff_cols;

  op_e              op_q;
  logic [ROW_W-1:0] row_q;
  logic [COL_W-1:0] col_q;
  logic             cell_q;
  logic             res_q;
  logic             cell_out_q;
  logic [RowAw-1:0] r_q;

  logic [MAX_COLS-1:0] first_q, prev_q, cur_q;
  logic [MAX_COLS-1:0] rd_row, down_row, new_row, mod_row;
  logic [MAX_COLS-1:0] ram_rdata, ram_wdata;
  logic [MAX_ROWS-1:0] rowv_q;
  logic                rd_valid_q;

  logic             in_area;
  logic             last_row;
  logic [RowAw-1:0] row_addr, rd_addr, wr_addr;
  logic [ColAw-1:0] col_idx;
  logic             ram_we;
  logic [RcW-1:0]   r_plus1, r_plus2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= GRID_ROWS_RST;
      grid_cols_q <= GRID_COLS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GRID_ROWS: grid_rows_q <= cfg_wdata_i[GRID_ROWS_W-1:0];
        CFG_GRID_COLS: grid_cols_q <= cfg_wdata_i[GRID_COLS_W-1:0];
        default: grid_rows_q <= grid_rows_q;
      endcase
    end
  end

  // Zero is taken as one and anything above the board size as the board size.
  always_comb begin
    if (grid_rows_q == '0) begin
      eff_rows = GRID_ROWS_W'(1);
    end else if (RcW'(grid_rows_q) > RcW'(MAX_ROWS)) begin
      eff_rows = GRID_ROWS_W'(MAX_ROWS);
    end else begin
      eff_rows = grid_rows_q;
    end
    if (grid_cols_q == '0) begin
      eff_cols = GRID_COLS_W'(1);
    end else if (CcW'(grid_cols_q) > CcW'(MAX_COLS)) begin
      eff_cols = GRID_COLS_W'(MAX_COLS);
    end else begin
      eff_cols = grid_cols_q;
    end
  end

  assign in_area  = (RcW'(row_q) < RcW'(eff_rows)) && (CcW'(col_q) < CcW'(eff_cols));
  assign row_addr = in_area ? RowAw'(row_q) : '0;
  assign col_idx  = ColAw'(col_q);
  assign last_row = (RcW'(r_q) + RcW'(1)) == RcW'(eff_rows);
  assign r_plus1  = RcW'(r_q) + RcW'(1);
  assign r_plus2  = RcW'(r_q) + RcW'(2);

  always_comb begin
    case (cmd_i.rd_sel)
      RA_ROW:   rd_addr = row_addr;
      RA_LAST:  rd_addr = RowAw'(RcW'(eff_rows) - RcW'(1));
      RA_ZERO:  rd_addr = '0;
      RA_NEXT1: rd_addr = (r_plus1 < RcW'(eff_rows)) ? RowAw'(r_plus1) : '0;
      RA_NEXT2: rd_addr = (r_plus2 < RcW'(eff_rows)) ? RowAw'(r_plus2) : '0;
      default:  rd_addr = '0;
    endcase
  end

  // A row never written since reset reads as all dead.
  assign rd_row   = rd_valid_q ? ram_rdata : '0;
  assign down_row = last_row ? first_q : rd_row;

  always_comb begin
    mod_row          = rd_row;
    mod_row[col_idx] = cell_q;
  end

  tlg_rule #(
    .MAX_COLS(MAX_COLS)
  ) u_rule (
    .prev_i    (prev_q),
    .cur_i     (cur_q),
    .down_i    (down_row),
    .eff_cols_i(eff_cols),
    .next_o    (new_row)
  );

  assign ram_we    = cmd_i.adv_row || (cmd_i.wr_cell && in_area);
  assign wr_addr   = cmd_i.adv_row ? r_q : row_addr;
  assign ram_wdata = cmd_i.adv_row ? new_row : mod_row;

  tlg_ram #(
    .WIDTH(MAX_COLS),
    .DEPTH(MAX_ROWS)
  ) u_board (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_addr),
    .wdata_i(ram_wdata),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rowv_q     <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (ram_we) begin
        rowv_q[wr_addr] <= 1'b1;
      end
      rd_valid_q <= rowv_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(operation_i);
      row_q  <= row_i;
      col_q  <= col_i;
      cell_q <= cell_in_i;
      res_q  <= 1'b0;
      r_q    <= '0;
    end
    if (cmd_i.cap_read) begin
      res_q <= in_area && rd_row[col_idx];
    end
    if (cmd_i.load_prev) begin
      prev_q <= rd_row;
    end
    if (cmd_i.load_first) begin
      first_q <= rd_row;
      cur_q   <= rd_row;
    end
    if (cmd_i.adv_row) begin
      prev_q <= cur_q;
      cur_q  <= down_row;
      r_q    <= r_q + RowAw'(1);
    end
    if (cmd_i.load_out) begin
      cell_out_q <= res_q;
    end
  end

  assign status_o.op       = op_q;
  assign status_o.last_row = last_row;
  assign cell_out_o        = cell_out_q;

endmodule

[hdl/toroidal_life_generation.sv]
// Channel | Direction | Payload                        | Handshake
// in_if   | sink      | operation, row, col, cell_in   | valid / ready
// out_if  | source    | cell_out                       | valid / ready
// cfg     | input     | cfg_index_i, cfg_wdata_i       | cfg_we_i, no stall
//
// A write or read goes through decode, a write-back or capture state and the done state, which
// loads its result; an advance goes through decode, the last-row, first-row and current-row
// reads and the row state, one board row per cycle through the board RAM's single read port.
// Reset clears the row valid bits at once, so the board reads dead with no clearing pass.
// A result waits in the output register while the next transaction is accepted; the
// block only stalls in its last step when that register is still full.
module toroidal_life_generation #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tlg_in_if.sink                         in_if,
  tlg_out_if.source                      out_if,
  input  logic                           cfg_we_i,
  input  logic [tlg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tlg_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import tlg_pkg::*;

  cmd_t    cmd;
  status_t status;

  tlg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tlg_dpath #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .operation_i(in_if.operation),
    .row_i      (in_if.row),
    .col_i      (in_if.col),
    .cell_in_i  (in_if.cell_in),
    .cell_out_o (out_if.cell_out),
    .cmd_i      (cmd),
    .status_o   (status)
  );

endmodule

[hdl/tlg_checker.sv]
module tlg_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic cell_out_i
);

  logic       in_acc, out_acc;
  logic [1:0] pending_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Transactions accepted whose result has not yet been taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 2'd0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cell_out_i))
    else $error("stalled result changed or vanished");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pending_q != 2'd0)
    else $error("result shown with no transaction outstanding");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more than two transactions outstanding");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input accepted while a transaction is in progress");

endmodule

bind toroidal_life_generation tlg_checker u_tlg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_if.valid),
  .in_ready_i (in_if.ready),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .cell_out_i (out_if.cell_out)
);
